// ----- rtl/core/sstc_pkg.sv -----
package sstc_pkg;

  localparam int unsigned CfgAddrW = 5;

  localparam logic [15:0] ResetInterval = 16'd12500;
  localparam logic [13:0] CrossLimit    = 14'd10000;
  localparam logic [7:0]  CountMax      = 8'd255;
  localparam logic [2:0]  StepLast      = 3'd5;

  localparam logic [2:0]  FixedStepsReset = 3'd2;
  localparam logic [7:0]  BadLimitReset   = 8'd2;

  typedef enum logic [2:0] {
    RegDirForward  = 3'd0,
    RegAutoMode    = 3'd1,
    RegFixedSteps  = 3'd2,
    RegAutoLevel   = 3'd3,
    RegBadLimit    = 3'd4,
    RegBrakeHold   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic       dir_forward;
    logic       auto_advance_mode;
    logic [2:0] fixed_advance_steps;
    logic [5:0] auto_adv_frac;
    logic [7:0] bad_count_limit;
    logic       brake_hold;
  } cfg_t;

endpackage

// ----- rtl/core/sstc_in_if.sv -----
interface sstc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        comp_level;
  logic [15:0] zc_time;

  modport source (output valid, output kind, output comp_level, output zc_time,
                  input ready);
  modport sink (input valid, input kind, input comp_level, input zc_time,
                output ready);
endinterface

// ----- rtl/core/sstc_out_if.sv -----
interface sstc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  drive_step;
  logic        drive_apply;
  logic        expect_rising;
  logic        step_wrapped;
  logic [15:0] interval_avg;
  logic [15:0] wait_ticks;
  logic [7:0]  good_count;
  logic [13:0] cross_count;

  modport source (output valid, output drive_step, output drive_apply,
                  output expect_rising, output step_wrapped, output interval_avg,
                  output wait_ticks, output good_count, output cross_count,
                  input ready);
  modport sink (input valid, input drive_step, input drive_apply,
                input expect_rising, input step_wrapped, input interval_avg,
                input wait_ticks, input good_count, input cross_count,
                output ready);
endinterface

// ----- rtl/core/sstc_cfg_regs.sv -----
module sstc_cfg_regs import sstc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[CfgAddrW-1:2])
        RegDirForward: cfg_d.dir_forward         = pwdata[0];
        RegAutoMode:   cfg_d.auto_advance_mode   = pwdata[0];
        RegFixedSteps: cfg_d.fixed_advance_steps = pwdata[2:0];
        RegAutoLevel:  cfg_d.auto_adv_frac       = pwdata[5:0];
        RegBadLimit:   cfg_d.bad_count_limit     = pwdata[7:0];
        RegBrakeHold:  cfg_d.brake_hold          = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[CfgAddrW-1:2])
      RegDirForward: prdata = {31'd0, cfg_q.dir_forward};
      RegAutoMode:   prdata = {31'd0, cfg_q.auto_advance_mode};
      RegFixedSteps: prdata = {29'd0, cfg_q.fixed_advance_steps};
      RegAutoLevel:  prdata = {26'd0, cfg_q.auto_adv_frac};
      RegBadLimit:   prdata = {24'd0, cfg_q.bad_count_limit};
      RegBrakeHold:  prdata = {31'd0, cfg_q.brake_hold};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_forward         <= 1'b1;
      cfg_q.auto_advance_mode   <= 1'b0;
      cfg_q.fixed_advance_steps <= FixedStepsReset;
      cfg_q.auto_adv_frac       <= 6'd0;
      cfg_q.bad_count_limit     <= BadLimitReset;
      cfg_q.brake_hold          <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/six_step_commutation_timing.sv -----
// A beat accepted into the input register has its result loaded into the output
// register once the output stage is empty or its result is being taken.
// Throughput: one beat per cycle unless the output stalls; one pass through the step,
// average and advance logic (a 16x6 multiply, or 13x3 in fixed mode) sets this figure.
// Reset: asynchronous active low; clears the valid flags of both stages, the commutation
// state (average interval to 12500) and the configuration registers to their defaults.
module six_step_commutation_timing import sstc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  sstc_in_if.sink             in_i,
  sstc_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t cfg;

  sstc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input stage.
  logic        in_vld_q;
  logic        kind_q, level_q;
  logic [15:0] zc_q;
  logic        advance;

  // Output stage.
  logic        out_vld_q;
  logic        apply_q, wrapped_q;

  // Commutation state.
  logic [2:0]  step_d, step_q;
  logic        edge_d, edge_q;
  logic [15:0] avg_d, avg_q;
  logic [15:0] wait_d, wait_q;
  logic [7:0]  good_d, good_q;
  logic [7:0]  bad_d, bad_q;
  logic [13:0] cross_d, cross_q;
  logic        apply_d, wrapped_d;

  logic [17:0] avg_sum;
  logic [15:0] avg_new;
  logic [15:0] adv_fixed;
  logic [21:0] adv_prod;
  logic [15:0] adv;
  logic [15:0] half;
  logic [7:0]  bad_inc;

  assign advance     = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready  = ~in_vld_q | advance;

  assign avg_sum   = {2'd0, avg_q} + {1'b0, avg_q, 1'b0} + {2'd0, zc_q};
  assign avg_new   = avg_sum[17:2];
  assign adv_fixed = {3'd0, avg_new[15:3]} * {13'd0, cfg.fixed_advance_steps};
  assign adv_prod  = {6'd0, avg_new} * {16'd0, cfg.auto_adv_frac};
  assign adv       = cfg.auto_advance_mode ? adv_prod[21:6] : adv_fixed;
  assign half      = {1'b0, avg_new[15:1]};
  assign bad_inc   = (bad_q < CountMax) ? bad_q + 8'd1 : bad_q;

  always_comb begin
    step_d    = step_q;
    edge_d    = edge_q;
    avg_d     = avg_q;
    wait_d    = wait_q;
    good_d    = good_q;
    bad_d     = bad_q;
    cross_d   = cross_q;
    apply_d   = 1'b0;
    wrapped_d = 1'b0;
    if (kind_q) begin
      if (cfg.dir_forward) begin
        if (step_q >= StepLast) begin
          step_d    = 3'd0;
          wrapped_d = 1'b1;
        end else begin
          step_d = step_q + 3'd1;
        end
        edge_d = step_d[0];
      end else begin
        if (step_q == 3'd0 || step_q > StepLast) begin
          step_d    = StepLast;
          wrapped_d = 1'b1;
        end else begin
          step_d = step_q - 3'd1;
        end
        edge_d = ~step_d[0];
      end
      apply_d = ~cfg.brake_hold;
      good_d  = 8'd0;
      bad_d   = 8'd0;
      avg_d   = avg_new;
      wait_d  = (half > adv) ? half - adv : 16'd0;
      if (cross_q < CrossLimit) begin
        cross_d = cross_q + 14'd1;
      end
    end else begin
      // The comparator is inverted, so a low level is a good rising sample.
      if (edge_q ^ level_q) begin
        if (good_q < CountMax) begin
          good_d = good_q + 8'd1;
        end
      end else begin
        bad_d = bad_inc;
        if (bad_inc > cfg.bad_count_limit) begin
          good_d = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      step_q    <= 3'd0;
      edge_q    <= 1'b0;
      avg_q     <= ResetInterval;
      wait_q    <= 16'd0;
      good_q    <= 8'd0;
      bad_q     <= 8'd0;
      cross_q   <= 14'd0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        step_q    <= step_d;
        edge_q    <= edge_d;
        avg_q     <= avg_d;
        wait_q    <= wait_d;
        good_q    <= good_d;
        bad_q     <= bad_d;
        cross_q   <= cross_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q  <= in_i.kind;
      level_q <= in_i.comp_level;
      zc_q    <= in_i.zc_time;
    end
    if (advance) begin
      apply_q   <= apply_d;
      wrapped_q <= wrapped_d;
    end
  end

  // The state registers double as the result payload.
  assign out_o.valid         = out_vld_q;
  assign out_o.drive_step    = step_q;
  assign out_o.drive_apply   = apply_q;
  assign out_o.expect_rising = edge_q;
  assign out_o.step_wrapped  = wrapped_q;
  assign out_o.interval_avg  = avg_q;
  assign out_o.wait_ticks    = wait_q;
  assign out_o.good_count    = good_q;
  assign out_o.cross_count   = cross_q;

endmodule

// ----- tb/sstc_tb_pkg.sv -----
`timescale 1ns / 1ps
package sstc_tb_pkg;

  typedef enum logic {
    KindSample    = 1'b0,
    KindCommutate = 1'b1
  } beat_kind_e;

endpackage

// ----- tb/sstc_drive_checker.sv -----
`timescale 1ns / 1ps
module sstc_drive_checker import sstc_pkg::*; import sstc_tb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  sstc_in_if                  in_mon,
  sstc_out_if                 out_mon,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [2:0]  drive_step;
    logic        drive_apply;
    logic        expect_rising;
    logic        step_wrapped;
    logic [15:0] interval_avg;
    logic [15:0] wait_ticks;
    logic [7:0]  good_count;
    logic [13:0] cross_count;
  } drive_report_t;

  cfg_t          cfg_q;
  logic [2:0]    step_q;
  logic          rising_q;
  logic [15:0]   avg_q;
  logic [15:0]   wait_q;
  logic [7:0]    good_q;
  logic [7:0]    bad_q;
  logic [13:0]   cross_q;

  drive_report_t expected_drive_q[$];
  drive_report_t predicted;
  drive_report_t want;
  int unsigned   results_seen;

  task automatic report_mismatch(input string msg);
    if (errors_o < 40) $display("%0t sstc_drive_checker: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_seen, name, got, exp_val));
  endtask

  // Moves the commutation state by one beat and returns the drive report it causes.
  task automatic advance_commutation_state(input beat_kind_e kind, input logic level,
                                           input logic [15:0] zc,
                                           output drive_report_t rep);
    logic [2:0]  next_step;
    logic        wrapped;
    logic [17:0] weighted;
    logic [15:0] avg;
    logic [21:0] advance;
    logic [15:0] half;
    logic        good;
    wrapped = 1'b0;
    rep.drive_apply = 1'b0;
    if (kind == KindCommutate) begin
      if (cfg_q.dir_forward) begin
        if (step_q >= StepLast) begin
          next_step = 3'd0;
          wrapped   = 1'b1;
        end else begin
          next_step = step_q + 3'd1;
        end
        rising_q = next_step[0];
      end else begin
        if (step_q == 3'd0 || step_q > StepLast) begin
          next_step = StepLast;
          wrapped   = 1'b1;
        end else begin
          next_step = step_q - 3'd1;
        end
        rising_q = ~next_step[0];
      end
      step_q = next_step;
      rep.drive_apply = ~cfg_q.brake_hold;
      good_q = 8'd0;
      bad_q  = 8'd0;

      weighted = 18'd3 * 18'(avg_q) + 18'(zc);
      avg      = weighted[17:2];
      avg_q    = avg;
      if (!cfg_q.auto_advance_mode) begin
        advance = 22'(avg[15:3]) * 22'(cfg_q.fixed_advance_steps);
      end else begin
        advance = 22'(avg) * 22'(cfg_q.auto_adv_frac);
        advance = advance >> 6;
      end
      half   = avg >> 1;
      wait_q = (22'(half) > advance) ? half - advance[15:0] : 16'd0;
      if (cross_q < CrossLimit) cross_q = cross_q + 14'd1;
    end else begin
      // The comparator output is inverted: a low level means the phase is high.
      good = rising_q ? ~level : level;
      if (good) begin
        if (good_q < CountMax) good_q = good_q + 8'd1;
      end else begin
        if (bad_q < CountMax) bad_q = bad_q + 8'd1;
        if (bad_q > cfg_q.bad_count_limit) good_q = 8'd0;
      end
    end
    rep.drive_step    = step_q;
    rep.expect_rising = rising_q;
    rep.step_wrapped  = wrapped;
    rep.interval_avg  = avg_q;
    rep.wait_ticks    = wait_q;
    rep.good_count    = good_q;
    rep.cross_count   = cross_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_forward         = 1'b1;
      cfg_q.auto_advance_mode   = 1'b0;
      cfg_q.fixed_advance_steps = FixedStepsReset;
      cfg_q.auto_adv_frac       = 6'd0;
      cfg_q.bad_count_limit     = BadLimitReset;
      cfg_q.brake_hold          = 1'b0;
      step_q   = 3'd0;
      rising_q = 1'b0;
      avg_q    = ResetInterval;
      wait_q   = 16'd0;
      good_q   = 8'd0;
      bad_q    = 8'd0;
      cross_q  = 14'd0;
      expected_drive_q.delete();
      results_seen = 0;
      errors_o  = 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[CfgAddrW-1:2]))
          RegDirForward: cfg_q.dir_forward         = pwdata[0];
          RegAutoMode:   cfg_q.auto_advance_mode   = pwdata[0];
          RegFixedSteps: cfg_q.fixed_advance_steps = pwdata[2:0];
          RegAutoLevel:  cfg_q.auto_adv_frac       = pwdata[5:0];
          RegBadLimit:   cfg_q.bad_count_limit     = pwdata[7:0];
          RegBrakeHold:  cfg_q.brake_hold          = pwdata[0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        advance_commutation_state(beat_kind_e'(in_mon.kind), in_mon.comp_level,
                                  in_mon.zc_time, predicted);
        expected_drive_q.push_back(predicted);
      end

      if (out_mon.valid && out_mon.ready) begin
        if (expected_drive_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = expected_drive_q.pop_front();
          check_field("drive_step", out_mon.drive_step, want.drive_step);
          check_field("drive_apply", out_mon.drive_apply, want.drive_apply);
          check_field("expect_rising", out_mon.expect_rising, want.expect_rising);
          check_field("step_wrapped", out_mon.step_wrapped, want.step_wrapped);
          check_field("interval_avg", out_mon.interval_avg, want.interval_avg);
          check_field("wait_ticks", out_mon.wait_ticks, want.wait_ticks);
          check_field("good_count", out_mon.good_count, want.good_count);
          check_field("cross_count", out_mon.cross_count, want.cross_count);
        end
        results_seen++;
      end

      pending_o <= expected_drive_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import sstc_pkg::*;
  import sstc_tb_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned beats_sent;
  int unsigned quiet_cycles;
  logic        idle_on;
  logic        hold_req;
  logic        hold_off;

  sstc_in_if  in_if ();
  sstc_out_if out_if ();

  six_step_commutation_timing u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sstc_drive_checker u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Long receiver hold-off so the block fills up and pushes back on its input.
  initial begin : pressure
    hold_off <= 1'b0;
    @(posedge clk_i iff hold_req);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : result_sink
    int unsigned gap;
    out_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      while (gap > 0 || hold_off) begin
        out_if.ready <= 1'b0;
        @(posedge clk_i);
        if (gap > 0) gap--;
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  function automatic logic [15:0] motor_zc_time();
    return $urandom_range(0, 1) ? 16'($urandom_range(2000, 20000)) : 16'($urandom);
  endfunction

  // Valid stays high between back-to-back beats; it only drops for a gap.
  task automatic send_beat(input beat_kind_e kind, input logic level,
                           input logic [15:0] zc);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.comp_level <= level;
    in_if.zc_time    <= zc;
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_phase(input logic [31:0] dir, input logic [31:0] auto_mode,
                           input logic [31:0] fixed, input logic [31:0] level,
                           input logic [31:0] limit, input logic [31:0] brake,
                           input bit idle);
    settle();
    write_reg(RegDirForward, dir);
    write_reg(RegAutoMode, auto_mode);
    write_reg(RegFixedSteps, fixed);
    write_reg(RegAutoLevel, level);
    write_reg(RegBadLimit, limit);
    write_reg(RegBrakeHold, brake);
    psel    <= 1'b0;
    penable <= 1'b0;
    idle_on <= idle;
  endtask

  // Mostly comparator runs that flip level once, as around a zero cross, then a
  // commutation; the rest is unstructured noise.
  task automatic run_phase(input int unsigned items, input bit with_pressure);
    int unsigned start;
    int unsigned lead;
    int unsigned trail;
    logic        lvl;
    start = beats_sent;
    while (beats_sent - start < items) begin
      if (with_pressure && !hold_req && beats_sent - start > items / 3) hold_req <= 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        lead  = $urandom_range(0, 8);
        trail = $urandom_range(0, 8);
        lvl   = 1'($urandom);
        repeat (lead) send_beat(KindSample, lvl, 16'($urandom));
        repeat (trail) send_beat(KindSample, ~lvl, 16'($urandom));
        send_beat(KindCommutate, 1'($urandom), motor_zc_time());
      end else begin
        repeat ($urandom_range(1, 6))
          send_beat(beat_kind_e'(1'($urandom)), 1'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KindSample;
    in_if.comp_level <= 1'b0;
    in_if.zc_time    <= 16'd0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= 32'd0;
    idle_on          <= 1'b1;
    hold_req         <= 1'b0;
    beats_sent       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: good counting, then enough bad samples to clear it.
    send_beat(KindSample, 1'b1, 16'hffff);
    send_beat(KindSample, 1'b1, 16'h0000);
    repeat (4) send_beat(KindSample, 1'b0, 16'($urandom));
    send_beat(KindSample, 1'b1, 16'($urandom));
    // Forward through the whole sequence and past the wrap, with zc extremes.
    send_beat(KindCommutate, 1'b0, 16'h0000);
    send_beat(KindCommutate, 1'b1, 16'hffff);
    repeat (4) send_beat(KindCommutate, 1'($urandom), 16'($urandom));
    send_beat(KindCommutate, 1'b0, 16'hffff);
    send_beat(KindSample, 1'b0, 16'($urandom));
    send_beat(KindSample, 1'b1, 16'($urandom));

    // Reverse with the brake held and an advance larger than half the interval.
    set_phase(32'd0, 32'd0, 32'd7, 32'd0, 32'd0, 32'd1, 1'b1);
    send_beat(KindCommutate, 1'b1, 16'hffff);
    send_beat(KindCommutate, 1'b0, 16'h0000);
    repeat (5) send_beat(KindCommutate, 1'($urandom), 16'($urandom));
    send_beat(KindSample, 1'b0, 16'($urandom));
    send_beat(KindSample, 1'b1, 16'($urandom));

    set_phase(32'd0, 32'd0, 32'd7, 32'd63, 32'd0, 32'd1, 1'b1);
    run_phase(150, 1'b0);

    set_phase(32'd1, 32'd1, 32'd0, 32'd63, 32'd255, 32'd0, 1'b0);
    run_phase(150, 1'b0);
    // Long runs of one level drive the sample counters into saturation.
    repeat (260) send_beat(KindSample, 1'b1, 16'($urandom));
    repeat (260) send_beat(KindSample, 1'b0, 16'($urandom));

    set_phase(32'd0, 32'd1, 32'd3, 32'd0, 32'd2, 32'd0, 1'b1);
    run_phase(150, 1'b1);

    set_phase($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
    run_phase(120, 1'b0);

    set_phase($urandom, $urandom, $urandom, $urandom, 32'($urandom_range(0, 8)),
              $urandom, 1'b0);
    run_phase(120, 1'b0);

    settle();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
